// ----- rtl/spq_pkg.sv -----
// Shared types and constants for the sorted priority queue.
`timescale 1ns / 1ps
package spq_pkg;

  localparam int CAPACITY_DEF      = 16;
  localparam int DATA_BITS_DEF     = 32;
  localparam int PRIORITY_BITS_DEF = 16;

  localparam logic CMD_ENQ = 1'b0;
  localparam logic CMD_DEQ = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Per-cycle command broadcast to every cell.
  typedef struct packed {
    logic enq;
    logic deq;
  } cell_ctl_t;

endpackage

// ----- rtl/spq_in_if.sv -----
// Request channel: command, data word and priority.
`timescale 1ns / 1ps
interface spq_in_if
  import spq_pkg::*;
#(
  parameter int DATA_BITS     = DATA_BITS_DEF,
  parameter int PRIORITY_BITS = PRIORITY_BITS_DEF
) ();
  logic                            valid;
  logic                            ready;
  logic                            command;
  logic [DATA_BITS-1:0]            item_data;
  logic signed [PRIORITY_BITS-1:0] item_priority;

  modport source (output valid, command, item_data, item_priority, input ready);
  modport sink (input valid, command, item_data, item_priority, output ready);
endinterface

// ----- rtl/spq_out_if.sv -----
// Response channel: removed head, status and fill count.
`timescale 1ns / 1ps
interface spq_out_if
  import spq_pkg::*;
#(
  parameter int DATA_BITS     = DATA_BITS_DEF,
  parameter int PRIORITY_BITS = PRIORITY_BITS_DEF,
  parameter int COUNT_BITS    = $clog2(CAPACITY_DEF + 1)
) ();
  logic                            valid;
  logic                            ready;
  logic [DATA_BITS-1:0]            out_data;
  logic signed [PRIORITY_BITS-1:0] out_priority;
  logic [1:0]                      status;
  logic [COUNT_BITS-1:0]           fill_count;

  modport source (output valid, out_data, out_priority, status, fill_count, input ready);
  modport sink (input valid, out_data, out_priority, status, fill_count, output ready);
endinterface

// ----- rtl/sorted_priority_queue.sv -----
// Channel  Dir   Fields
// in_ch    sink  command, item_data, item_priority
// out_ch   src   out_data, out_priority, status, fill_count
//
// All cells compare against the new priority at once and shift in the same
// edge, so an item can be accepted every cycle that in_ch.ready allows.
// The response sits in an output register; a new item is taken whenever
// that register is empty or being drained. Reset clears the fill count and
// the output valid; cell contents are meaningful only below the fill count.
`timescale 1ns / 1ps
module sorted_priority_queue
  import spq_pkg::*;
#(
  parameter int CAPACITY      = CAPACITY_DEF,
  parameter int DATA_BITS     = DATA_BITS_DEF,
  parameter int PRIORITY_BITS = PRIORITY_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  spq_in_if.sink     in_ch,
  spq_out_if.source  out_ch
);

  localparam int CNT_BITS = $clog2(CAPACITY + 1);

  logic [CNT_BITS-1:0]             count;
  logic                            accept;
  logic                            full;
  logic                            empty;
  cell_ctl_t                       ctl;
  logic [CAPACITY-1:0]             used;
  logic [CAPACITY-1:0]             cell_ge;
  logic [DATA_BITS-1:0]            cell_data [CAPACITY];
  logic signed [PRIORITY_BITS-1:0] cell_prio [CAPACITY];

  assign full   = (count == CNT_BITS'(CAPACITY));
  assign empty  = (count == '0);
  assign in_ch.ready = !out_ch.valid || out_ch.ready;
  assign accept = in_ch.valid && in_ch.ready;
  assign ctl = '{enq: accept && (in_ch.command == CMD_ENQ) && !full,
                 deq: accept && (in_ch.command == CMD_DEQ) && !empty};

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                            l_ge;
    logic [DATA_BITS-1:0]            l_data;
    logic signed [PRIORITY_BITS-1:0] l_prio;
    logic [DATA_BITS-1:0]            r_data;
    logic signed [PRIORITY_BITS-1:0] r_prio;

    assign used[i] = (count > CNT_BITS'(i));

    if (i == 0) begin : g_head
      assign l_ge   = 1'b0;
      assign l_data = in_ch.item_data;
      assign l_prio = in_ch.item_priority;
    end else begin : g_mid
      assign l_ge   = cell_ge[i-1];
      assign l_data = cell_data[i-1];
      assign l_prio = cell_prio[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign r_data = '0;
      assign r_prio = '0;
    end else begin : g_body
      assign r_data = cell_data[i+1];
      assign r_prio = cell_prio[i+1];
    end

    spq_cell #(
      .DATA_BITS     (DATA_BITS),
      .PRIORITY_BITS (PRIORITY_BITS)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .used       (used[i]),
      .new_data   (in_ch.item_data),
      .new_prio   (in_ch.item_priority),
      .left_ge    (l_ge),
      .left_data  (l_data),
      .left_prio  (l_prio),
      .right_data (r_data),
      .right_prio (r_prio),
      .ge         (cell_ge[i]),
      .data       (cell_data[i]),
      .prio       (cell_prio[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= '0;
      out_ch.valid <= 1'b0;
    end else begin
      if (accept) begin
        out_ch.valid <= 1'b1;
        if (in_ch.command == CMD_ENQ) begin
          out_ch.out_data     <= '0;
          out_ch.out_priority <= '0;
          if (full) begin
            out_ch.status     <= ST_FULL;
            out_ch.fill_count <= count;
          end else begin
            out_ch.status     <= ST_DONE;
            count             <= count + 1'b1;
            out_ch.fill_count <= count + 1'b1;
          end
        end else begin
          if (empty) begin
            out_ch.out_data     <= '0;
            out_ch.out_priority <= '0;
            out_ch.status       <= ST_EMPTY;
            out_ch.fill_count   <= count;
          end else begin
            out_ch.out_data     <= cell_data[0];
            out_ch.out_priority <= cell_prio[0];
            out_ch.status       <= ST_DONE;
            count               <= count - 1'b1;
            out_ch.fill_count   <= count - 1'b1;
          end
        end
      end else if (out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_BITS'(CAPACITY))
    else $error("fill count above capacity");

  a_head_order: assert property (@(posedge clk) disable iff (rst)
    (count >= CNT_BITS'(2)) |-> (cell_prio[0] >= cell_prio[1]))
    else $error("head cells out of priority order");

  a_deq_head: assert property (@(posedge clk) disable iff (rst)
    ctl.deq |=> (out_ch.out_priority == $past(cell_prio[0]))
                && (out_ch.out_data == $past(cell_data[0])))
    else $error("dequeue did not return the head");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.status == ST_FULL)
      |-> (out_ch.fill_count == CNT_BITS'(CAPACITY)))
    else $error("full status with queue not full");

endmodule

// ----- rtl/spq_cell.sv -----
// One slot of the sorted chain: holds an entry and shifts toward either neighbor.
`timescale 1ns / 1ps
module spq_cell
  import spq_pkg::*;
#(
  parameter int DATA_BITS     = DATA_BITS_DEF,
  parameter int PRIORITY_BITS = PRIORITY_BITS_DEF
) (
  input  logic                            clk,
  input  cell_ctl_t                       ctl,
  input  logic                            used,
  input  logic [DATA_BITS-1:0]            new_data,
  input  logic signed [PRIORITY_BITS-1:0] new_prio,
  input  logic                            left_ge,
  input  logic [DATA_BITS-1:0]            left_data,
  input  logic signed [PRIORITY_BITS-1:0] left_prio,
  input  logic [DATA_BITS-1:0]            right_data,
  input  logic signed [PRIORITY_BITS-1:0] right_prio,
  output logic                            ge,
  output logic [DATA_BITS-1:0]            data,
  output logic signed [PRIORITY_BITS-1:0] prio
);

  // New item belongs at or ahead of this slot.
  assign ge = !used || (new_prio >= prio);

  always_ff @(posedge clk) begin
    if (ctl.enq) begin
      if (left_ge) begin
        data <= left_data;
        prio <= left_prio;
      end else if (ge) begin
        data <= new_data;
        prio <= new_prio;
      end
    end else if (ctl.deq) begin
      data <= right_data;
      prio <= right_prio;
    end
  end

endmodule
